### src/crt_index_sequence_generator_core_defines.svh
// assertion macros shared by the checker
`ifndef CRT_INDEX_SEQUENCE_GENERATOR_CORE_DEFINES_SVH
`define CRT_INDEX_SEQUENCE_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CISG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cisg checker: property violated");

// next-cycle implication, sampled on clk_i, off during reset
`define CISG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cisg checker: property violated");

`endif

### src/cisg_pkg.sv
package cisg_pkg;

  localparam int unsigned MaxFactors  = 4;
  localparam int unsigned IndexBits   = 16;
  localparam int unsigned LaneBits    = 16;
  localparam int unsigned LenBits     = IndexBits + 1;
  localparam int unsigned CntBits     = 3;
  localparam int unsigned RegIdxBits  = 3;
  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned FacIdxBits  = (MaxFactors > 1) ? $clog2(MaxFactors) : 1;
  localparam int unsigned ItemBits    = $clog2(MaxFactors + 1);
  localparam int unsigned BitCntBits  = $clog2(IndexBits + 1);

  typedef enum logic [RegIdxBits-1:0] {
    RegLength      = 3'd0,
    RegFactorCount = 3'd1,
    RegRadices     = 3'd2,
    RegDecStrides  = 3'd3,
    RegRecStrides  = 3'd4,
    RegDirection   = 3'd5
  } reg_idx_e;

  typedef logic [IndexBits-1:0] index_t;

  typedef struct packed {
    logic [LenBits-1:0]            len;
    index_t                        len_m1;
    logic [CntBits-1:0]            count;
    index_t [MaxFactors-1:0]       radix;
    index_t [MaxFactors-1:0]       cum;
  } step_cfg_t;

  typedef struct packed {
    logic   valid;
    index_t value;
  } idx_load_t;

  typedef struct packed {
    logic   last;
    index_t position;
    index_t mapped;
  } result_t;

  // (a + b) mod n for a, b below n
  function automatic logic [LenBits-1:0] mod_add(index_t a, index_t b,
                                                 logic [LenBits-1:0] n);
    logic [LenBits-1:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= n) begin
      sum = sum - n;
    end
    return sum;
  endfunction

endpackage

### src/cisg_rem.sv
module cisg_rem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  cisg_pkg::index_t                 dividend_i,
  input  logic [cisg_pkg::LenBits-1:0]     divisor_i,
  output logic                             done_o,
  output cisg_pkg::index_t                 rem_o
);

  logic                                run_q;
  logic                                done_q;
  logic [cisg_pkg::BitCntBits-1:0]     cnt_q;
  cisg_pkg::index_t                    x_q;
  cisg_pkg::index_t                    r_q;
  logic [cisg_pkg::LenBits-1:0]        trial;
  cisg_pkg::index_t                    r_d;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {r_q, x_q[cisg_pkg::IndexBits-1]};
    if (trial >= divisor_i) begin
      r_d = cisg_pkg::IndexBits'(trial - divisor_i);
    end else begin
      r_d = trial[cisg_pkg::IndexBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= cisg_pkg::BitCntBits'(cisg_pkg::IndexBits);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == cisg_pkg::BitCntBits'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
      r_q <= '0;
    end else if (run_q) begin
      x_q <= x_q << 1;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

### src/cisg_setup.sv
module cisg_setup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cisg_pkg::RegIdxBits-1:0]     cfg_index_i,
  input  logic [cisg_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  cisg_pkg::index_t                    run_index_i,
  output logic                                busy_o,
  output cisg_pkg::step_cfg_t                 step_cfg_o,
  output cisg_pkg::idx_load_t                 idx_load_o
);

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StWait,
    StPrefix
  } state_e;

  state_e                                      state_q;
  logic [cisg_pkg::LaneBits-1:0]               len_q;
  logic [cisg_pkg::CntBits-1:0]                fcount_q;
  logic [cisg_pkg::CfgDataBits-1:0]            radices_q;
  logic [cisg_pkg::CfgDataBits-1:0]            dec_q;
  logic [cisg_pkg::CfgDataBits-1:0]            rec_q;
  logic                                        dir_q;
  cisg_pkg::index_t [cisg_pkg::MaxFactors-1:0] red_q;
  cisg_pkg::index_t [cisg_pkg::MaxFactors-1:0] cum_q;
  cisg_pkg::index_t                            acc_q;
  logic [cisg_pkg::ItemBits-1:0]               item_q;
  logic [cisg_pkg::FacIdxBits-1:0]             dig_q;
  cisg_pkg::idx_load_t                         idx_load_q;

  logic [cisg_pkg::LenBits-1:0]                len_eff;
  logic [cisg_pkg::CntBits-1:0]                count;
  logic [cisg_pkg::CfgDataBits-1:0]            strides;
  cisg_pkg::index_t                            dividend;
  logic                                        rem_done;
  cisg_pkg::index_t                            rem;
  logic [cisg_pkg::LenBits-1:0]                acc_sum;
  cisg_pkg::index_t                            acc_d;
  logic                                        last_item;

  always_comb begin
    if (len_q[cisg_pkg::IndexBits-1:0] == '0) begin
      len_eff = cisg_pkg::LenBits'(1) << cisg_pkg::IndexBits;
    end else begin
      len_eff = {1'b0, len_q[cisg_pkg::IndexBits-1:0]};
    end
    if (fcount_q > cisg_pkg::CntBits'(cisg_pkg::MaxFactors)) begin
      count = cisg_pkg::CntBits'(cisg_pkg::MaxFactors);
    end else begin
      count = fcount_q;
    end
    strides   = dir_q ? rec_q : dec_q;
    last_item = (item_q == cisg_pkg::ItemBits'(cisg_pkg::MaxFactors));
    if (last_item) begin
      dividend = run_index_i;
    end else begin
      dividend = strides[cisg_pkg::LaneBits * item_q[cisg_pkg::FacIdxBits-1:0]
                         +: cisg_pkg::IndexBits];
    end
    acc_sum = cisg_pkg::mod_add(acc_q, red_q[dig_q], len_eff);
    if (cisg_pkg::CntBits'(dig_q) < count) begin
      acc_d = acc_sum[cisg_pkg::IndexBits-1:0];
    end else begin
      acc_d = '0;
    end
  end

  cisg_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StLoad),
    .dividend_i (dividend),
    .divisor_i  (len_eff),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      len_q      <= cisg_pkg::LaneBits'(1);
      fcount_q   <= '0;
      radices_q  <= '0;
      dec_q      <= '0;
      rec_q      <= '0;
      dir_q      <= 1'b0;
      red_q      <= '0;
      cum_q      <= '0;
      acc_q      <= '0;
      item_q     <= '0;
      dig_q      <= '0;
      idx_load_q <= '0;
    end else begin
      idx_load_q.valid <= 1'b0;
      if (cfg_valid_i) begin
        case (cisg_pkg::reg_idx_e'(cfg_index_i))
          cisg_pkg::RegLength:      len_q     <= cfg_data_i[cisg_pkg::LaneBits-1:0];
          cisg_pkg::RegFactorCount: fcount_q  <= cfg_data_i[cisg_pkg::CntBits-1:0];
          cisg_pkg::RegRadices:     radices_q <= cfg_data_i;
          cisg_pkg::RegDecStrides:  dec_q     <= cfg_data_i;
          cisg_pkg::RegRecStrides:  rec_q     <= cfg_data_i;
          cisg_pkg::RegDirection:   dir_q     <= cfg_data_i[0];
          default: ;
        endcase
        // any write reruns the stride reduction
        state_q <= StLoad;
        item_q  <= '0;
      end else begin
        case (state_q)
          StIdle: ;
          StLoad: begin
            state_q <= StWait;
          end
          StWait: begin
            if (rem_done) begin
              if (last_item) begin
                idx_load_q.valid <= 1'b1;
                idx_load_q.value <= rem;
                state_q          <= StPrefix;
                dig_q            <= cisg_pkg::FacIdxBits'(cisg_pkg::MaxFactors - 1);
                acc_q            <= '0;
              end else begin
                red_q[item_q[cisg_pkg::FacIdxBits-1:0]] <= rem;
                item_q  <= item_q + 1'b1;
                state_q <= StLoad;
              end
            end
          end
          StPrefix: begin
            // suffix sums of reduced strides, top digit down
            acc_q        <= acc_d;
            cum_q[dig_q] <= acc_d;
            if (dig_q == '0) begin
              state_q <= StIdle;
            end else begin
              dig_q <= dig_q - 1'b1;
            end
          end
          default: state_q <= StIdle;
        endcase
      end
    end
  end

  always_comb begin
    step_cfg_o.len    = len_eff;
    step_cfg_o.len_m1 = cisg_pkg::IndexBits'(len_eff - 1'b1);
    step_cfg_o.count  = count;
    for (int k = 0; k < cisg_pkg::MaxFactors; k++) begin
      step_cfg_o.radix[k] = radices_q[cisg_pkg::LaneBits * k +: cisg_pkg::IndexBits];
    end
    step_cfg_o.cum = cum_q;
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != StIdle);
  assign idx_load_o  = idx_load_q;

endmodule

### src/cisg_step.sv
module cisg_step (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   restart_i,
  input  cisg_pkg::step_cfg_t    cfg_i,
  input  cisg_pkg::idx_load_t    idx_load_i,
  output cisg_pkg::result_t      result_o,
  output cisg_pkg::index_t       run_index_o
);

  cisg_pkg::index_t [cisg_pkg::MaxFactors-1:0] digit_q;
  cisg_pkg::index_t                            run_q;
  cisg_pkg::index_t                            red_q;
  cisg_pkg::index_t                            pos_q;

  cisg_pkg::index_t [cisg_pkg::MaxFactors-1:0] cur_dig;
  cisg_pkg::index_t [cisg_pkg::MaxFactors-1:0] digit_d;
  cisg_pkg::index_t                            cur_run;
  cisg_pkg::index_t                            cur_red;
  cisg_pkg::index_t                            cur_pos;
  cisg_pkg::index_t                            run_d;
  cisg_pkg::index_t                            red_d;
  cisg_pkg::index_t                            pos_d;
  logic [cisg_pkg::LenBits-1:0]                incr [cisg_pkg::MaxFactors];
  logic [cisg_pkg::MaxFactors-1:0]             active;
  logic [cisg_pkg::MaxFactors-1:0]             no_carry;
  logic                                        found;
  logic [cisg_pkg::FacIdxBits-1:0]             stop;
  cisg_pkg::index_t                            amount;
  logic [cisg_pkg::LenBits-1:0]                sum;
  logic                                        is_last;

  always_comb begin
    cur_dig = restart_i ? '0 : digit_q;
    cur_run = restart_i ? '0 : run_q;
    cur_red = restart_i ? '0 : red_q;
    cur_pos = restart_i ? '0 : pos_q;
    is_last = (cur_pos == cfg_i.len_m1);

    for (int d = 0; d < cisg_pkg::MaxFactors; d++) begin
      active[d]   = (cisg_pkg::CntBits'(d) < cfg_i.count);
      incr[d]     = {1'b0, cur_dig[d]} + 1'b1;
      no_carry[d] = active[d] && (incr[d] < {1'b0, cfg_i.radix[d]});
    end

    // lowest-order digit that absorbs the carry
    found = 1'b0;
    stop  = '0;
    for (int d = 0; d < cisg_pkg::MaxFactors; d++) begin
      if (no_carry[d]) begin
        found = 1'b1;
        stop  = cisg_pkg::FacIdxBits'(d);
      end
    end

    if (cfg_i.count == '0) begin
      amount = '0;
    end else if (found) begin
      amount = cfg_i.cum[stop];
    end else begin
      amount = cfg_i.cum[0];
    end
    sum = cisg_pkg::mod_add(cur_red, amount, cfg_i.len);

    for (int d = 0; d < cisg_pkg::MaxFactors; d++) begin
      if (!active[d] || (found && (cisg_pkg::FacIdxBits'(d) < stop))) begin
        digit_d[d] = cur_dig[d];
      end else if (found && (cisg_pkg::FacIdxBits'(d) == stop)) begin
        digit_d[d] = incr[d][cisg_pkg::IndexBits-1:0];
      end else begin
        digit_d[d] = '0;
      end
    end

    if (is_last) begin
      digit_d = '0;
      run_d   = '0;
      red_d   = '0;
      pos_d   = '0;
    end else begin
      red_d = (cfg_i.count == '0) ? cur_red : sum[cisg_pkg::IndexBits-1:0];
      run_d = (cfg_i.count == '0) ? cur_run : sum[cisg_pkg::IndexBits-1:0];
      pos_d = cur_pos + 1'b1;
    end

    result_o.mapped   = cur_run;
    result_o.position = cur_pos;
    result_o.last     = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      run_q   <= '0;
      red_q   <= '0;
      pos_q   <= '0;
    end else if (idx_load_i.valid) begin
      red_q <= idx_load_i.value;
    end else if (accept_i) begin
      digit_q <= digit_d;
      run_q   <= run_d;
      red_q   <= red_d;
      pos_q   <= pos_d;
    end
  end

  assign run_index_o = run_q;

endmodule

### src/crt_index_sequence_generator_core.sv
// a result is registered in the output register in the cycle after its request is taken
// one request per cycle while not busy and the output is not stalled; the digit/carry update is combinational
// after each config write the strides are reduced mod the length by a bit-serial
// remainder unit; s_axis_tready_o stays low meanwhile
// reset: rst_ni async active low; length 1, other config registers and all counters zero
module crt_index_sequence_generator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,  // restart
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [31:0]                         m_axis_tdata_o,  // position (upper), mapped_index (lower)
  output logic                                m_axis_tlast_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cisg_pkg::RegIdxBits-1:0]     cfg_index_i,
  input  logic [cisg_pkg::CfgDataBits-1:0]    cfg_data_i
);

  logic                    busy;
  logic                    accept;
  logic                    out_valid_q;
  cisg_pkg::result_t       out_q;
  cisg_pkg::result_t       result;
  cisg_pkg::step_cfg_t     step_cfg;
  cisg_pkg::idx_load_t     idx_load;
  cisg_pkg::index_t        run_index;

  cisg_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .run_index_i (run_index),
    .busy_o      (busy),
    .step_cfg_o  (step_cfg),
    .idx_load_o  (idx_load)
  );

  cisg_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .restart_i   (s_axis_tdata_i[0]),
    .cfg_i       (step_cfg),
    .idx_load_i  (idx_load),
    .result_o    (result),
    .run_index_o (run_index)
  );

  assign s_axis_tready_o = !busy && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.position, out_q.mapped};
  assign m_axis_tlast_o  = out_q.last;

endmodule

### src/cisg_checker.sv
`include "crt_index_sequence_generator_core_defines.svh"

module cisg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  logic in_take;
  logic out_stall;
  logic cfg_take;

  assign in_take   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign cfg_take  = cfg_valid_i && cfg_ready_o;

  // stalled result holds
  `CISG_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // every taken request shows up in the output register next cycle
  `CISG_ASSERT_NEXT(a_req_to_result, in_take, m_axis_tvalid_o)

  // restart starts at position zero with index zero
  `CISG_ASSERT_NEXT(a_restart_zero, in_take && s_axis_tdata_i[0], m_axis_tdata_o == 32'd0)

  // config write starts the stride reduction, requests held off
  `CISG_ASSERT_NEXT(a_cfg_blocks, cfg_take, !s_axis_tready_o)

endmodule

bind crt_index_sequence_generator_core cisg_checker u_cisg_checker (.*);
